[design/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the key set toggle table.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int KEY_W   = 48;
   localparam int COUNT_W = 4;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_TOGGLE = 1'b1;

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic capture;
      logic remove;
      logic append;
   } cell_ctrl_type;

endpackage

[design/kst_if.sv]
// ----------------------------------------------------------------------------
// kst_if
// Request and response channels of the key set toggle table.
// ----------------------------------------------------------------------------
interface kst_req_if
   import kst_pkg::*;
   ;
   logic    valid;
   logic    ready;
   logic    func;
   key_type peer_key;

   modport source (output valid, output func, output peer_key, input ready);
   modport sink   (input valid, input func, input peer_key, output ready);
endinterface

interface kst_rsp_if
   import kst_pkg::*;
   ;
   logic      valid;
   logic      ready;
   logic      was_member;
   logic      now_member;
   logic      add_refused;
   count_type entry_count;

   modport source (output valid, output was_member, output now_member,
                   output add_refused, output entry_count, input ready);
   modport sink   (input valid, input was_member, input now_member,
                   input add_refused, input entry_count, output ready);
endinterface

[design/kst_cell.sv]
// ----------------------------------------------------------------------------
// kst_cell
// One slot of the key list: holds a key, compares it, shifts from its neighbor.
// ----------------------------------------------------------------------------
module kst_cell
   import kst_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_ctrl_type    ctrl,
   input  logic [CNT_W-1:0] count,
   input  key_type          probe_key,
   input  key_type          append_key,
   input  key_type          next_key,
   input  logic             seen_in,
   output logic             seen_out,
   output logic             match,
   output key_type          key
);

   key_type key_ff;
   key_type key_in;
   logic    match_ff;
   logic    match_in;
   logic    occupied;
   logic    seen;

   assign occupied = count > CNT_W'(INDEX);
   assign seen     = seen_in | match_ff;
   assign seen_out = seen;
   assign match    = match_ff;
   assign key      = key_ff;

   always_comb begin
      match_in = match_ff;
      key_in   = key_ff;
      if (ctrl.capture) begin
         match_in = occupied && (key_ff == probe_key);
      end
      if (ctrl.remove && seen) begin
         key_in = next_key;
      end else if (ctrl.append && (count == CNT_W'(INDEX))) begin
         key_in = append_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

[design/key_set_toggle_table_unit.sv]
// One request is in flight at a time: compare into the cell row, then prefix
// chain and shift/append; a new request is not taken until the update step for
// the current one is done.
// A waiting response stalls the update step until it is taken.
// Reset (synchronous, active high) empties the list and clears all valids;
// key storage itself is not cleared.
// ----------------------------------------------------------------------------
// key_set_toggle_table_unit
// Compact set of 48-bit keys with lookup and toggle built from a row of cells.
// ----------------------------------------------------------------------------
module key_set_toggle_table_unit
   import kst_pkg::*;
#(
   parameter int MAX_ENTRIES = 8
) (
   input  logic      clock,
   input  logic      reset,
   kst_req_if.sink   req_ch,
   kst_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic             busy_ff;
   logic             func_ff;
   key_type          req_key_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             was_ff;
   logic             now_ff;
   logic             refused_ff;
   count_type        entry_ff;

   logic                   accept;
   logic                   done;
   logic                   hit;
   logic                   not_full;
   logic                   toggle;
   logic [MAX_ENTRIES-1:0] match_vec;
   logic [MAX_ENTRIES:0]   seen_vec;
   key_type                key_vec  [MAX_ENTRIES];
   key_type                next_vec [MAX_ENTRIES];
   cell_ctrl_type          ctrl;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign accept   = req_ch.valid && !busy_ff;
   assign done     = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign hit      = |match_vec;
   assign not_full = count_ff < CNT_W'(MAX_ENTRIES);
   assign toggle   = func_ff == FUNC_TOGGLE;

   assign ctrl.capture = accept;
   assign ctrl.remove  = done && toggle && hit;
   assign ctrl.append  = done && toggle && !hit && not_full;

   assign seen_vec[0] = 1'b0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign next_vec[i] = key_vec[i];
      end else begin : g_mid
         assign next_vec[i] = key_vec[i+1];
      end

      kst_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .probe_key  (req_ch.peer_key),
         .append_key (req_key_ff),
         .next_key   (next_vec[i]),
         .seen_in    (seen_vec[i]),
         .seen_out   (seen_vec[i+1]),
         .match      (match_vec[i]),
         .key        (key_vec[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctrl.append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_ch.func;
         req_key_ff <= req_ch.peer_key;
      end
      if (done) begin
         was_ff     <= hit;
         now_ff     <= toggle ? (!hit && not_full) : hit;
         refused_ff <= toggle && !hit && !not_full;
         entry_ff   <= count_ext[COUNT_W-1:0];
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ch.ready       = !busy_ff;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.was_member  = was_ff;
   assign rsp_ch.now_member  = now_ff;
   assign rsp_ch.add_refused = refused_ff;
   assign rsp_ch.entry_count = entry_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above capacity");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $countones(match_vec) <= 1)
      else $error("key matched in more than one slot");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1)
      || count_ff == $past(count_ff) - CNT_W'(1))
      else $error("entry count moved by more than one");

   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && refused_ff |-> count_ff == CNT_W'(MAX_ENTRIES))
      else $error("add refused while list not full");
`endif

endmodule
